/* hdl/b2da_pkg.sv */
`default_nettype none

package b2da_pkg;

  // Width of the binary input value.
  localparam int BIN_W = 32;

  // Decimal digits a 32-bit value can have.
  localparam int BCD_MAX = 10;

  // Character field width and its byte-padded bus width.
  localparam int CHAR_W = 6;
  localparam int OUT_DATA_W = 8;

  // ASCII code of the digit zero, masked to the character width.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Shift count at which the last conversion step runs.
  localparam logic [4:0] LAST_SHIFT = 5'(BIN_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic dec_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic shift_done;
    logic digit_zero;
    logic idx_zero;
  } status_t;

endpackage

`default_nettype wire

/* hdl/b2da_ctrl.sv */
`default_nettype none

module b2da_ctrl
  import b2da_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  wire     m_tready,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    s_tready    = 1'b0;
    m_tvalid    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.shift_done) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Step past leading zeros; the lowest digit is always sent.
        if (status.digit_zero && !status.idx_zero) begin
          cmd.dec_idx = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (status.idx_zero) begin
            state_next = ST_IDLE;
          end else begin
            cmd.dec_idx = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/b2da_dp.sv */
`default_nettype none

module b2da_dp
  import b2da_pkg::*;
#(
  parameter int NDIG = 10
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire  [BIN_W-1:0]      value,
  input  wire                   to_lcd,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [CHAR_W-1:0]     ascii_char,
  output logic                  dest_lcd,
  output logic                  last
);

  localparam int BCD_W = 4 * NDIG;
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(NDIG - 1);

  logic [BIN_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] bcd_adj;
  logic [4:0]       cnt;
  logic [IDX_W-1:0] idx;
  logic             dest;
  logic [3:0]       digit;

  // Add three to every digit of five or more before the doubling shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Shift counter and digit pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
      idx <= IDX_TOP;
    end else begin
      if (cmd.shift) begin
        cnt <= cnt + 5'd1;
      end
      if (cmd.dec_idx) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  // Conversion registers. Carries out of the top digit drop, which keeps
  // the value modulo ten to the number of digit positions.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin  <= value;
      bcd  <= '0;
      dest <= to_lcd;
    end else if (cmd.shift) begin
      bin <= {bin[BIN_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[BIN_W-1]};
    end
  end

  assign digit = bcd[idx*4 +: 4];

  // Status back to the controller.
  assign status.shift_done = (cnt == LAST_SHIFT);
  assign status.digit_zero = (digit == 4'd0);
  assign status.idx_zero   = (idx == '0);

  // Character fields of the current digit.
  assign ascii_char = ASCII_ZERO + CHAR_W'(digit);
  assign dest_lcd   = dest;
  assign last       = (idx == '0);

endmodule

`default_nettype wire

/* hdl/binary_to_decimal_ascii.sv */
// Operation: an accepted value is converted by the bit-serial shift-add-3 loop,
// then leading zeros are skipped one digit per cycle, and the remaining digits
// are sent as characters. A new value is accepted only after the last
// character of the previous value has been taken.
// Reset: synchronous, active high; returns the controller to idle.
`default_nettype none

module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  wire  [BIN_W-1:0]      s_tdata,  // [31:0] value
  input  wire                   s_tuser,  // [0] to_lcd
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // [5:0] ascii_char, [7:6] zero
  output logic                  m_tuser,  // [0] dest_lcd
  output logic                  m_tlast
);

  // Positions beyond ten always hold zero for a 32-bit value.
  localparam int NDIG = (MAX_DIGITS < BCD_MAX) ? MAX_DIGITS : BCD_MAX;

  cmd_t              cmd;
  status_t           status;
  logic [CHAR_W-1:0] ascii_char;

  // Controller.
  b2da_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath.
  b2da_dp #(
    .NDIG (NDIG)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (s_tdata),
    .to_lcd     (s_tuser),
    .cmd        (cmd),
    .status     (status),
    .ascii_char (ascii_char),
    .dest_lcd   (m_tuser),
    .last       (m_tlast)
  );

  // Pad the character to a whole byte.
  assign m_tdata = {(OUT_DATA_W - CHAR_W)'(0), ascii_char};

endmodule

`default_nettype wire
